@@ hw/rtl/hhs_pkg.sv @@
// Shared constants, codes and lookup functions for the HTTP header scanner.
// Used by the scanner top level and its port checker; depends on nothing.
package hhs_pkg;

    localparam int NAME_MAX_DEF  = 32;
    localparam int VALUE_MAX_DEF = 128;

    // Length of the header name "user-agent".
    localparam int KEY_LEN = 10;

    localparam logic [1:0] CMD_FEED    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] STATUS_SCANNING = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [1:0] STATUS_ERROR    = 2'd2;

    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_VT    = 8'h0b;
    localparam logic [7:0] CHAR_FF    = 8'h0c;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3a;

    // Lower-case spelling of the header name that selects the agent string.
    function automatic logic [7:0] agent_key_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h75; // u
            4'd1:    ch = 8'h73; // s
            4'd2:    ch = 8'h65; // e
            4'd3:    ch = 8'h72; // r
            4'd4:    ch = 8'h2d; // -
            4'd5:    ch = 8'h61; // a
            4'd6:    ch = 8'h67; // g
            4'd7:    ch = 8'h65; // e
            4'd8:    ch = 8'h6e; // n
            4'd9:    ch = 8'h74; // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] ch);
        logic [7:0] res;
        res = ch;
        if (ch >= 8'h41 && ch <= 8'h5a) begin
            res = ch + 8'h20;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/hhs_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for the value and agent byte buffers of the scanner.
module hhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/http_header_scanner_top.sv @@
// HTTP header scanner: one transfer per cycle while not stalled; each result passes through the
// buffer read stage and then the output register, and is held there longer under stall.
// Throughput is one byte or command per cycle while the input side is not stalled.
// Reset (synchronous, active low) returns the scan to its begin state and empties the agent
// string; the two byte buffers are not cleared and are only read where they were written.
// Depends on hhs_pkg and hhs_ram.
module http_header_scanner_top #(
    parameter int NAME_MAX  = hhs_pkg::NAME_MAX_DEF,
    parameter int VALUE_MAX = hhs_pkg::VALUE_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_read_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_scan_status,
    output logic       o_header_done,
    output logic       o_agent_updated,
    output logic [6:0] o_agent_length,
    output logic [7:0] o_agent_byte
);

    // Name counter width holds NAME_MAX-1; buffer address width holds VALUE_MAX-1.
    localparam int NW     = $clog2(NAME_MAX);
    localparam int AW     = $clog2(VALUE_MAX);
    localparam int LEXT_W = AW + 7;

    localparam logic [NW-1:0] NAME_LIM = NW'(NAME_MAX - 1);
    localparam logic [NW-1:0] KEY_CNT  = NW'(hhs_pkg::KEY_LEN);
    localparam logic [AW-1:0] VAL_LIM  = AW'(VALUE_MAX - 1);

    typedef enum logic [6:0] {
        ST_BEGIN    = 7'b0000001,
        ST_NAME     = 7'b0000010,
        ST_VALUE    = 7'b0000100,
        ST_HDREND   = 7'b0001000,
        ST_SCANEND  = 7'b0010000,
        ST_COMPLETE = 7'b0100000,
        ST_ERROR    = 7'b1000000
    } t_scan_state;

    // The design keeps two byte buffers of VALUE_MAX entries. One holds the current agent
    // string, the other collects the value of the header being scanned. When a user-agent
    // header ends, the roles swap and the leading whitespace count becomes the agent start
    // offset, so no copy of the string is ever needed. Writes always go to the value
    // buffer and reads to the agent buffer, so the two never meet on one memory.

    t_scan_state r_state, n_state;
    logic [NW-1:0] r_name_cnt, n_name_cnt;
    logic          r_name_match, n_name_match;
    logic [AW-1:0] r_val_cnt, n_val_cnt;
    logic [AW-1:0] r_lead, n_lead;
    logic          r_all_ws, n_all_ws;
    logic          r_sel, n_sel;
    logic [AW-1:0] r_agent_start, n_agent_start;
    logic [AW-1:0] r_agent_len, n_agent_len;

    // Read stage: control fields of the transfer whose buffer read is in flight.
    logic       r_s1_valid;
    logic [1:0] r_s1_status;
    logic       r_s1_done;
    logic       r_s1_upd;
    logic [6:0] r_s1_len;
    logic       r_s1_rd;
    logic       r_s1_sel;

    // Output register.
    logic       r_o_valid;
    logic [1:0] r_o_status;
    logic       r_o_done;
    logic       r_o_upd;
    logic [6:0] r_o_len;
    logic [7:0] r_o_byte;

    logic accept;
    logic s1_adv;
    logic done;
    logic upd;
    logic rd;
    logic wr;
    logic hit;
    logic is_ws;
    logic [NW-1:0]     take_cnt;
    logic              take_match;
    logic [LEXT_W-1:0] idx_ext;
    logic [LEXT_W-1:0] len_cur_ext;
    logic [LEXT_W-1:0] len_new_ext;
    logic [LEXT_W-1:0] addr_sum;
    logic [AW-1:0]     rd_addr;
    logic [1:0]        status;
    logic [7:0]        rd_data0;
    logic [7:0]        rd_data1;
    logic [7:0]        lower_byte;

    // The input side stalls only when the read stage is full and cannot move on.
    assign s1_adv  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && r_o_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Name byte intake: counts up to NAME_MAX-1 and tracks the match against the key.
    assign lower_byte = hhs_pkg::to_lower(i_data_byte);
    always_comb begin
        take_cnt   = r_name_cnt;
        take_match = r_name_match;
        if (r_name_cnt < NAME_LIM) begin
            if (r_name_cnt >= KEY_CNT ||
                lower_byte != hhs_pkg::agent_key_char(r_name_cnt[3:0])) begin
                take_match = 1'b0;
            end
            take_cnt = r_name_cnt + NW'(1);
        end
    end

    assign is_ws = (i_data_byte == hhs_pkg::CHAR_SP) || (i_data_byte == hhs_pkg::CHAR_HT) ||
                   (i_data_byte == hhs_pkg::CHAR_VT) || (i_data_byte == hhs_pkg::CHAR_FF);

    assign hit = r_name_match && (r_name_cnt == KEY_CNT);

    // Agent read address: start offset plus index, valid only below the stored length.
    assign idx_ext     = LEXT_W'(i_read_index);
    assign len_cur_ext = LEXT_W'(r_agent_len);
    assign addr_sum    = LEXT_W'(r_agent_start) + idx_ext;
    assign rd_addr     = addr_sum[AW-1:0];

    always_comb begin
        n_state       = r_state;
        n_name_cnt    = r_name_cnt;
        n_name_match  = r_name_match;
        n_val_cnt     = r_val_cnt;
        n_lead        = r_lead;
        n_all_ws      = r_all_ws;
        n_sel         = r_sel;
        n_agent_start = r_agent_start;
        n_agent_len   = r_agent_len;
        done          = 1'b0;
        upd           = 1'b0;
        rd            = 1'b0;
        wr            = 1'b0;
        case (i_cmd)
            hhs_pkg::CMD_FEED: begin
                case (r_state)
                    ST_BEGIN: begin
                        if (i_data_byte == hhs_pkg::CHAR_CR) begin
                            n_state = ST_SCANEND;
                        end else if (i_data_byte == hhs_pkg::CHAR_LF) begin
                            n_state = ST_COMPLETE;
                        end else begin
                            n_name_cnt   = take_cnt;
                            n_name_match = take_match;
                            n_state      = ST_NAME;
                        end
                    end
                    ST_NAME: begin
                        if (i_data_byte == hhs_pkg::CHAR_COLON) begin
                            n_val_cnt = '0;
                            n_lead    = '0;
                            n_all_ws  = 1'b1;
                            n_state   = ST_VALUE;
                        end else if (i_data_byte <= hhs_pkg::CHAR_SP) begin
                            n_state = ST_ERROR;
                        end else begin
                            n_name_cnt   = take_cnt;
                            n_name_match = take_match;
                        end
                    end
                    ST_VALUE: begin
                        if (i_data_byte == hhs_pkg::CHAR_CR) begin
                            n_state = ST_HDREND;
                        end else if (i_data_byte == hhs_pkg::CHAR_LF) begin
                            done = 1'b1;
                        end else if (r_val_cnt < VAL_LIM) begin
                            wr        = 1'b1;
                            n_val_cnt = r_val_cnt + AW'(1);
                            if (r_all_ws && is_ws) begin
                                n_lead = r_lead + AW'(1);
                            end else begin
                                n_all_ws = 1'b0;
                            end
                        end
                    end
                    ST_HDREND: begin
                        if (i_data_byte == hhs_pkg::CHAR_LF) begin
                            done = 1'b1;
                        end else begin
                            n_state = ST_ERROR;
                        end
                    end
                    ST_SCANEND: begin
                        n_state = (i_data_byte == hhs_pkg::CHAR_LF) ? ST_COMPLETE : ST_ERROR;
                    end
                    default: begin
                        // A byte after completion, or any byte in error, is an error.
                        n_state = ST_ERROR;
                    end
                endcase
                if (done) begin
                    // End of a header line: swap buffers on a user-agent header.
                    upd = hit;
                    if (hit) begin
                        n_sel         = ~r_sel;
                        n_agent_start = r_lead;
                        n_agent_len   = r_val_cnt - r_lead;
                    end
                    n_state      = ST_BEGIN;
                    n_name_cnt   = '0;
                    n_name_match = 1'b1;
                    n_val_cnt    = '0;
                    n_lead       = '0;
                    n_all_ws     = 1'b1;
                end
            end
            hhs_pkg::CMD_RESTART: begin
                n_state      = ST_BEGIN;
                n_name_cnt   = '0;
                n_name_match = 1'b1;
                n_val_cnt    = '0;
                n_lead       = '0;
                n_all_ws     = 1'b1;
            end
            hhs_pkg::CMD_READ: begin
                rd = (idx_ext < len_cur_ext);
            end
            default: begin
                // The unused command leaves all state alone and reads nothing.
            end
        endcase
    end

    always_comb begin
        case (n_state)
            ST_COMPLETE: status = hhs_pkg::STATUS_COMPLETE;
            ST_ERROR:    status = hhs_pkg::STATUS_ERROR;
            default:     status = hhs_pkg::STATUS_SCANNING;
        endcase
    end

    assign len_new_ext = LEXT_W'(n_agent_len);

    // Buffer zero collects values while r_sel is high; buffer one while it is low.
    hhs_ram #(
        .WIDTH (8),
        .DEPTH (VALUE_MAX)
    ) u_buf0 (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr && r_sel),
        .i_wr_addr (r_val_cnt),
        .i_wr_data (i_data_byte),
        .i_rd_en   (accept && rd && !r_sel),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data0)
    );

    hhs_ram #(
        .WIDTH (8),
        .DEPTH (VALUE_MAX)
    ) u_buf1 (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr && !r_sel),
        .i_wr_addr (r_val_cnt),
        .i_wr_data (i_data_byte),
        .i_rd_en   (accept && rd && r_sel),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_BEGIN;
            r_name_cnt    <= '0;
            r_name_match  <= 1'b1;
            r_val_cnt     <= '0;
            r_lead        <= '0;
            r_all_ws      <= 1'b1;
            r_sel         <= 1'b0;
            r_agent_start <= '0;
            r_agent_len   <= '0;
        end else if (accept) begin
            r_state       <= n_state;
            r_name_cnt    <= n_name_cnt;
            r_name_match  <= n_name_match;
            r_val_cnt     <= n_val_cnt;
            r_lead        <= n_lead;
            r_all_ws      <= n_all_ws;
            r_sel         <= n_sel;
            r_agent_start <= n_agent_start;
            r_agent_len   <= n_agent_len;
        end
    end

    // Read stage. The RAM read data holds while the stage waits, since a read is only
    // issued together with a new transfer into this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= status;
            r_s1_done   <= done;
            r_s1_upd    <= upd;
            r_s1_len    <= len_new_ext[6:0];
            r_s1_rd     <= rd;
            r_s1_sel    <= r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_status <= r_s1_status;
            r_o_done   <= r_s1_done;
            r_o_upd    <= r_s1_upd;
            r_o_len    <= r_s1_len;
            r_o_byte   <= r_s1_rd ? (r_s1_sel ? rd_data1 : rd_data0) : 8'h00;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_scan_status   = r_o_status;
    assign o_header_done   = r_o_done;
    assign o_agent_updated = r_o_upd;
    assign o_agent_length  = r_o_len;
    assign o_agent_byte    = r_o_byte;

endmodule

@@ hw/rtl/hhs_checker.sv @@
// Port-level checker for the HTTP header scanner, bound to its top level.
// Depends on hhs_pkg for the status codes.
module hhs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_scan_status,
    input logic       o_header_done,
    input logic       o_agent_updated,
    input logic [6:0] o_agent_length,
    input logic [7:0] o_agent_byte
);

    // A stalled result transfer keeps its status, agent length and agent byte on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_scan_status) &&
        $stable(o_agent_length) && $stable(o_agent_byte))
        else $error("result changed while stalled");

    // The input side can only be held off while a result is waiting.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // An agent update only happens at the end of a header line.
    a_upd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_agent_updated |-> o_header_done)
        else $error("agent update without header end");

    // A finished header line always returns the scan to scanning.
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_header_done |-> o_scan_status == hhs_pkg::STATUS_SCANNING)
        else $error("header end with non-scanning status");

endmodule

bind http_header_scanner_top hhs_checker u_hhs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_scan_status   (o_scan_status),
    .o_header_done   (o_header_done),
    .o_agent_updated (o_agent_updated),
    .o_agent_length  (o_agent_length),
    .o_agent_byte    (o_agent_byte)
);

@@ tb/http_header_scanner_top_test.sv @@
// Self-checking testbench for the HTTP header scanner: a queued driver, a monitor and a
// transfer-level predictor of scan state, name match and stored agent string.
// Depends on hhs_pkg and on http_header_scanner_top with its default parameters.
module http_header_scanner_top_test;

    // Scanner buffer sizes, matching the default parameters of the instance.
    localparam int NAME_LIM  = hhs_pkg::NAME_MAX_DEF;
    localparam int VALUE_LIM = hhs_pkg::VALUE_MAX_DEF;

    // Command code that the block does not use; it must behave like a read returning zero.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [8*hhs_pkg::KEY_LEN-1:0] AGENT_NAME = "user-agent";

    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_CAP = 40;

    typedef enum logic [2:0] {
        PS_START,
        PS_NAME,
        PS_VALUE,
        PS_HDR_CR,
        PS_END_CR,
        PS_FINISHED,
        PS_FAULT
    } t_pred_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic [6:0] idx;
    } t_scan_item;

    typedef struct packed {
        logic [1:0] status;
        logic       done;
        logic       updated;
        logic [6:0] length;
        logic [7:0] abyte;
    } t_scan_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_cmd = hhs_pkg::CMD_FEED;
    logic [7:0] i_data_byte = 8'h00;
    logic [6:0] i_read_index = 7'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_scan_status;
    logic       o_header_done;
    logic       o_agent_updated;
    logic [6:0] o_agent_length;
    logic [7:0] o_agent_byte;

    http_header_scanner_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_scan_status   (o_scan_status),
        .o_header_done   (o_header_done),
        .o_agent_updated (o_agent_updated),
        .o_agent_length  (o_agent_length),
        .o_agent_byte    (o_agent_byte)
    );

    // Clock with a period of eight time units.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Items waiting to be driven, and results predicted but not yet seen.
    t_scan_item   pending_items[$];
    t_scan_result expected_results[$];

    int total_items = 0;
    int sent_count = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit in_fired = 1'b0;
    t_scan_item next_item;

    // ------------------------------------------------------------------
    // Predictor state: the scan position, the running name comparison, the
    // value buffer of the current line and the stored agent string.
    // ------------------------------------------------------------------
    t_pred_state scan_st;
    int          name_cnt;
    bit          name_ok;
    int          val_cnt;
    logic [7:0]  val_buf [VALUE_LIM];
    logic [7:0]  agent_buf [VALUE_LIM];
    int          agent_cnt;

    function automatic logic [7:0] key_char(input int pos);
        return AGENT_NAME[8*(hhs_pkg::KEY_LEN-1-pos) +: 8];
    endfunction

    function automatic bit is_blank(input logic [7:0] ch);
        return ch == hhs_pkg::CHAR_SP || ch == hhs_pkg::CHAR_HT ||
               ch == hhs_pkg::CHAR_VT || ch == hhs_pkg::CHAR_FF;
    endfunction

    function automatic void clear_scan();
        scan_st = PS_START;
        name_cnt = 0;
        name_ok = 1'b1;
        val_cnt = 0;
    endfunction

    // Names are compared as they arrive; anything past the buffer is dropped.
    function automatic void add_name_char(input logic [7:0] ch);
        logic [7:0] lc;
        lc = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
        if (name_cnt < NAME_LIM - 1) begin
            if (name_cnt >= hhs_pkg::KEY_LEN || lc != key_char(name_cnt)) begin
                name_ok = 1'b0;
            end
            name_cnt++;
        end
    endfunction

    // Closes a header line. A user-agent header replaces the stored string with its
    // value, leading blanks removed; the last such header wins.
    function automatic bit end_header_line();
        int first;
        bit hit;
        hit = name_ok && name_cnt == hhs_pkg::KEY_LEN;
        if (hit) begin
            first = 0;
            while (first < val_cnt && is_blank(val_buf[first])) begin
                first++;
            end
            agent_cnt = val_cnt - first;
            for (int k = 0; k < agent_cnt; k++) begin
                agent_buf[k] = val_buf[first + k];
            end
        end
        clear_scan();
        return hit;
    endfunction

    // Advances the predicted scanner by one accepted transfer and returns its result.
    task automatic scan_transfer(input logic [1:0] cmd, input logic [7:0] ch,
                                 input logic [6:0] idx, output t_scan_result res);
        res = '0;
        if (cmd == hhs_pkg::CMD_FEED) begin
            case (scan_st)
                PS_START: begin
                    if (ch == hhs_pkg::CHAR_CR) begin
                        scan_st = PS_END_CR;
                    end else if (ch == hhs_pkg::CHAR_LF) begin
                        scan_st = PS_FINISHED;
                    end else begin
                        add_name_char(ch);
                        scan_st = PS_NAME;
                    end
                end
                PS_NAME: begin
                    if (ch == hhs_pkg::CHAR_COLON) begin
                        val_cnt = 0;
                        scan_st = PS_VALUE;
                    end else if (ch <= hhs_pkg::CHAR_SP) begin
                        scan_st = PS_FAULT;
                    end else begin
                        add_name_char(ch);
                    end
                end
                PS_VALUE: begin
                    if (ch == hhs_pkg::CHAR_CR) begin
                        scan_st = PS_HDR_CR;
                    end else if (ch == hhs_pkg::CHAR_LF) begin
                        res.done = 1'b1;
                        res.updated = end_header_line();
                    end else if (val_cnt < VALUE_LIM - 1) begin
                        val_buf[val_cnt] = ch;
                        val_cnt++;
                    end
                end
                PS_HDR_CR: begin
                    if (ch == hhs_pkg::CHAR_LF) begin
                        res.done = 1'b1;
                        res.updated = end_header_line();
                    end else begin
                        scan_st = PS_FAULT;
                    end
                end
                PS_END_CR: begin
                    scan_st = (ch == hhs_pkg::CHAR_LF) ? PS_FINISHED : PS_FAULT;
                end
                default: begin
                    scan_st = PS_FAULT;
                end
            endcase
        end else if (cmd == hhs_pkg::CMD_RESTART) begin
            clear_scan();
        end else if (cmd == hhs_pkg::CMD_READ) begin
            if (idx < agent_cnt) begin
                res.abyte = agent_buf[idx];
            end
        end
        res.status = (scan_st == PS_FINISHED) ? hhs_pkg::STATUS_COMPLETE :
                     (scan_st == PS_FAULT) ? hhs_pkg::STATUS_ERROR : hhs_pkg::STATUS_SCANNING;
        res.length = agent_cnt[6:0];
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    task automatic add_item(input logic [1:0] cmd, input logic [7:0] ch, input logic [6:0] idx);
        t_scan_item it;
        it.cmd = cmd;
        it.data = ch;
        it.idx = idx;
        pending_items.push_back(it);
    endtask

    // The read index is don't-care on a feed, so it is randomised to exercise its bits.
    task automatic add_byte(input logic [7:0] ch);
        add_item(hhs_pkg::CMD_FEED, ch, 7'($urandom_range(127)));
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(8'h21, 8'hff));
        if (ch == hhs_pkg::CHAR_COLON) begin
            ch = 8'h7e;
        end
        return ch;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(255));
        if (ch == hhs_pkg::CHAR_CR || ch == hhs_pkg::CHAR_LF) begin
            ch = ~ch;
        end
        return ch;
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] ch;
        case ($urandom_range(3))
            0:       ch = hhs_pkg::CHAR_SP;
            1:       ch = hhs_pkg::CHAR_HT;
            2:       ch = hhs_pkg::CHAR_VT;
            default: ch = hhs_pkg::CHAR_FF;
        endcase
        return ch;
    endfunction

    // Mostly the agent name in mixed case, otherwise near misses, other names and
    // names running past the name buffer.
    task automatic add_name();
        int kind;
        int len;
        logic [7:0] ch;
        kind = $urandom_range(99);
        if (kind < 55) begin
            for (int k = 0; k < hhs_pkg::KEY_LEN; k++) begin
                ch = key_char(k);
                if ($urandom_range(1) == 1 && ch >= "a" && ch <= "z") begin
                    ch = ch - 8'd32;
                end
                add_byte(ch);
            end
        end else if (kind < 70) begin
            len = hhs_pkg::KEY_LEN - 1 + $urandom_range(2);
            for (int k = 0; k < len; k++) begin
                add_byte((k < hhs_pkg::KEY_LEN) ? key_char(k) : name_char());
            end
            if (len == hhs_pkg::KEY_LEN) begin
                // Same length as the key, so spoil one character instead.
                pending_items[pending_items.size() - 1 -
                              $urandom_range(hhs_pkg::KEY_LEN - 1)].data = name_char();
            end
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 12)) add_byte(name_char());
        end else begin
            len = $urandom_range(NAME_LIM - 3, NAME_LIM + 12);
            for (int k = 0; k < len; k++) begin
                add_byte((k < hhs_pkg::KEY_LEN) ? key_char(k) : name_char());
            end
        end
    endtask

    task automatic add_header_line();
        int blanks;
        int body;
        int pick;
        logic [7:0] ch;
        // The first byte of a line is taken as a name byte unless it is CR or LF.
        if ($urandom_range(99) < 5) begin
            ch = 8'($urandom_range(0, hhs_pkg::CHAR_COLON));
            if (ch == hhs_pkg::CHAR_CR || ch == hhs_pkg::CHAR_LF) begin
                ch = hhs_pkg::CHAR_COLON;
            end
            add_byte(ch);
        end
        add_name();
        add_byte(hhs_pkg::CHAR_COLON);
        blanks = ($urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
        pick = $urandom_range(99);
        body = (pick < 6) ? $urandom_range(VALUE_LIM - 28, VALUE_LIM + 12) :
               (pick < 15) ? 0 : $urandom_range(1, 24);
        repeat (blanks) add_byte(blank_char());
        repeat (body) add_byte(value_char());
        if ($urandom_range(99) < 70) begin
            add_byte(hhs_pkg::CHAR_CR);
        end
        add_byte(hhs_pkg::CHAR_LF);
    endtask

    // Malformed fragments that put the scan into error until a restart, or a run of random transfers.
    task automatic add_broken();
        logic [7:0] ch;
        case ($urandom_range(3))
            0: begin
                repeat ($urandom_range(1, 5)) add_byte(name_char());
                add_byte(8'($urandom_range(0, hhs_pkg::CHAR_SP)));
            end
            1: begin
                repeat ($urandom_range(1, 5)) add_byte(name_char());
                add_byte(hhs_pkg::CHAR_COLON);
                repeat ($urandom_range(0, 4)) add_byte(value_char());
                add_byte(hhs_pkg::CHAR_CR);
                ch = 8'($urandom_range(255));
                add_byte((ch == hhs_pkg::CHAR_LF) ? hhs_pkg::CHAR_CR : ch);
            end
            2: begin
                add_byte(hhs_pkg::CHAR_CR);
                ch = 8'($urandom_range(255));
                add_byte((ch == hhs_pkg::CHAR_LF) ? hhs_pkg::CHAR_SP : ch);
            end
            default: begin
                repeat ($urandom_range(1, 8)) begin
                    add_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                             7'($urandom_range(127)));
                end
            end
        endcase
    endtask

    task automatic add_read();
        logic [6:0] idx;
        idx = ($urandom_range(1) == 1) ? 7'($urandom_range(15)) : 7'($urandom_range(127));
        add_item(($urandom_range(9) == 0) ? CMD_SPARE : hhs_pkg::CMD_READ,
                 8'($urandom_range(255)), idx);
    endtask

    // One request: restart, a few header lines, the blank line, then agent reads.
    task automatic add_request();
        add_item(hhs_pkg::CMD_RESTART, 8'($urandom_range(255)), 7'($urandom_range(127)));
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(99) < 12) begin
                add_broken();
            end
            add_header_line();
        end
        if ($urandom_range(1) == 1) begin
            add_byte(hhs_pkg::CHAR_CR);
        end
        add_byte(hhs_pkg::CHAR_LF);
        if ($urandom_range(99) < 25) begin
            add_byte(8'($urandom_range(255)));
        end
        repeat ($urandom_range(1, 4)) add_read();
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items at the falling edge. A presented item is
    // held until the block takes it, and the sender idles only between transfers.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        case (sent_count * 3 / total_items)
            0: begin
                send_idle_pct = 19;
                recv_idle_pct = 75;
            end
            1: begin
                send_idle_pct = 75;
                recv_idle_pct = 19;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        if (!i_valid || in_fired) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                sent_count++;
                i_valid <= 1'b1;
                i_cmd <= next_item.cmd;
                i_data_byte <= next_item.data;
                i_read_index <= next_item.idx;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic check_field(input string what, input logic [7:0] expv, input logic [7:0] gotv);
        if (expv !== gotv) begin
            fail_count++;
            if (fail_count <= REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expv, gotv);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: at each rising edge the accepted input transfer is predicted
    // first, then any accepted output transfer is checked against the oldest
    // prediction, so the order holds even for a very short latency.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_scan_result predicted;
        t_scan_result oldest;
        in_fired = i_rst_n && i_valid && !o_stall;
        if (in_fired) begin
            scan_transfer(i_cmd, i_data_byte, i_read_index, predicted);
            expected_results.push_back(predicted);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: result transfer with nothing expected, status %0h", $time,
                         o_scan_status);
            end else begin
                oldest = expected_results.pop_front();
                check_field("scan_status", 8'(oldest.status), 8'(o_scan_status));
                check_field("header_done", 8'(oldest.done), 8'(o_header_done));
                check_field("agent_updated", 8'(oldest.updated), 8'(o_agent_updated));
                check_field("agent_length", 8'(oldest.length), 8'(o_agent_length));
                check_field("agent_byte", oldest.abyte, o_agent_byte);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        clear_scan();
        agent_cnt = 0;

        // Directed opening: reads of an empty agent string at both index extremes, the
        // unused command, a mixed-case agent header whose value starts with tab and
        // vertical tab and holds a zero byte and a top-bit byte, a lone LF ending the
        // headers, a byte after completion, the sticky error, and reads after restart.
        add_item(hhs_pkg::CMD_RESTART, 8'h00, 7'd0);
        add_item(hhs_pkg::CMD_READ, 8'h00, 7'd0);
        add_item(hhs_pkg::CMD_READ, 8'hff, 7'd127);
        add_item(CMD_SPARE, 8'hff, 7'd127);
        add_byte("U");
        add_byte("s");
        add_byte("E");
        add_byte("r");
        add_byte("-");
        add_byte("A");
        add_byte("g");
        add_byte("e");
        add_byte("N");
        add_byte("t");
        add_byte(hhs_pkg::CHAR_COLON);
        add_byte(hhs_pkg::CHAR_HT);
        add_byte(hhs_pkg::CHAR_VT);
        add_byte("A");
        add_byte(8'h00);
        add_byte(8'hff);
        add_byte(hhs_pkg::CHAR_CR);
        add_byte(hhs_pkg::CHAR_LF);
        add_byte(hhs_pkg::CHAR_LF);
        add_byte("A");
        add_byte(hhs_pkg::CHAR_CR);
        add_item(hhs_pkg::CMD_RESTART, 8'hff, 7'd127);
        add_item(hhs_pkg::CMD_READ, 8'h00, 7'd2);
        add_item(hhs_pkg::CMD_READ, 8'h00, 7'd3);

        while (pending_items.size() < ITEM_TARGET) begin
            add_request();
        end
        total_items = pending_items.size();

        // Reset is held from the start and released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        // A short tail catches any stray result transfer after the last one.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
